/* src/fm_two_operator_oscillator_assert.svh */
// assertion helpers shared by the oscillator modules
`ifndef FM_TWO_OPERATOR_OSCILLATOR_ASSERT_SVH
`define FM_TWO_OPERATOR_OSCILLATOR_ASSERT_SVH

// concurrent assertion on a named clock and active-low reset
`define FMO_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the module's own clk_i and rst_ni
`define FMO_ASSERT(label, prop, msg) `FMO_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* src/fmo_pkg.sv */
package fmo_pkg;

  // table and field geometry
  localparam int unsigned TableSize = 1024;
  localparam int unsigned AddrW     = $clog2(TableSize);
  localparam int unsigned FracW     = 16;
  localparam int unsigned PhaseW    = AddrW + FracW;
  localparam int unsigned StepW     = 25;
  localparam int unsigned DepthW    = 24;
  localparam int unsigned AmpW      = 16;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned CfgDataW  = 25;
  localparam int unsigned CfgIdxW   = 2;

  // digit-serial multiplier geometry
  localparam int unsigned DigitW    = 4;
  localparam int unsigned MulBW     = DepthW;
  localparam int unsigned McandW    = 34;
  localparam int unsigned AccW      = McandW + DigitW;
  localparam int unsigned DigCntW   = 3;
  localparam logic [DigCntW-1:0] FracDigits  = DigCntW'(FracW / DigitW);
  localparam logic [DigCntW-1:0] DepthDigits = DigCntW'(DepthW / DigitW);

  // depth product is Q31 * Q12.12, offset wants Q16: total shift 27
  localparam int unsigned OffShift  = 27 - DigitW * (DepthW / DigitW);
  // amplitude product keeps weight 2^16 in hi, output shift is 31
  localparam int unsigned OutShift  = 31 - FracW;

  localparam logic [63:0] OneQ30    = 64'd1073741824;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCarrierStep = 2'd0,
    CfgModStep     = 2'd1,
    CfgModDepth    = 2'd2,
    CfgAmplitude   = 2'd3
  } fmo_cfg_e;

  typedef enum logic [3:0] {
    StIdle,
    StRdMod,
    StLerpMod,
    StDepth,
    StRdCar,
    StLdCar,
    StLerpCar,
    StAmp,
    StDone
  } fmo_state_e;

  typedef struct packed {
    logic                      start;
    logic [DigCntW-1:0]        ndig;
    logic signed [AccW-1:0]    init;
    logic signed [McandW-1:0]  mcand;
    logic [MulBW-1:0]          mplier;
  } fmo_mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [AccW-1:0]    hi;
    logic [MulBW-1:0]          lo;
  } fmo_mul_rsp_t;

  // one sine table entry, integer taylor series over the first quadrant
  function automatic logic signed [15:0] sine_entry(input int unsigned idx);
    logic [63:0]        f;
    logic [1:0]         quad;
    logic [63:0]        r;
    logic [63:0]        theta;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        mag;
    logic signed [15:0] m16;
    f     = 64'(idx) << (32 - AddrW);
    quad  = f[31:30];
    r     = f & (OneQ30 - 64'd1);
    if (quad[0]) begin
      r = OneQ30 - r;
    end
    theta = (r * HalfPiQ30) >> 30;
    t2    = (theta * theta) >> 30;
    term  = theta;
    sum   = $signed(theta);
    term  = ((term * t2) >> 30) / 64'd6;
    sum   = sum - $signed(term);
    term  = ((term * t2) >> 30) / 64'd20;
    sum   = sum + $signed(term);
    term  = ((term * t2) >> 30) / 64'd42;
    sum   = sum - $signed(term);
    term  = ((term * t2) >> 30) / 64'd72;
    sum   = sum + $signed(term);
    term  = ((term * t2) >> 30) / 64'd110;
    sum   = sum - $signed(term);
    term  = ((term * t2) >> 30) / 64'd156;
    sum   = sum + $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    mag = (64'(sum) * 64'd32767 + (OneQ30 >> 1)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    m16 = 16'(mag);
    return quad[1] ? -m16 : m16;
  endfunction

endpackage

/* src/fmo_rom.sv */
module fmo_rom
  import fmo_pkg::*;
(
  input  logic                    clk_i,
  input  logic [AddrW-1:0]        idx_i,
  output logic signed [15:0]      a_o,
  output logic signed [15:0]      b_o
);

  logic signed [15:0] rom_w [TableSize];
  logic [AddrW-1:0]   idx_next;
  logic signed [15:0] a_q;
  logic signed [15:0] b_q;

  for (genvar gi = 0; gi < TableSize; gi++) begin : g_rom
    assign rom_w[gi] = sine_entry(gi);
  end

  // right neighbour wraps from the last entry to entry 0
  assign idx_next = idx_i + AddrW'(1);

  always_ff @(posedge clk_i) begin
    a_q <= rom_w[idx_i];
    b_q <= rom_w[idx_next];
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

/* src/fmo_dmul.sv */
`include "fm_two_operator_oscillator_assert.svh"

module fmo_dmul
  import fmo_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fmo_mul_req_t  req_i,
  output fmo_mul_rsp_t  rsp_o
);

  logic                     run_q;
  logic                     done_q;
  logic [DigCntW-1:0]       cnt_q;
  logic signed [McandW-1:0] mcand_q;
  logic signed [AccW-1:0]   hi_q;
  logic signed [AccW-1:0]   hi_d;
  logic [MulBW-1:0]         lo_q;
  logic [MulBW-1:0]         lo_d;
  logic signed [AccW-1:0]   mc_ext;
  logic signed [AccW-1:0]   pp;
  logic signed [AccW-1:0]   sum;

  // one multiplier digit per cycle, product shifts out into lo
  always_comb begin
    mc_ext = AccW'(mcand_q);
    pp     = mc_ext * $signed({{(AccW-DigitW){1'b0}}, lo_q[DigitW-1:0]});
    sum    = hi_q + pp;
    hi_d   = sum >>> DigitW;
    lo_d   = {sum[DigitW-1:0], lo_q[MulBW-1:DigitW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= req_i.ndig;
      end else if (run_q) begin
        cnt_q <= cnt_q - DigCntW'(1);
        if (cnt_q == DigCntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mcand_q <= req_i.mcand;
      hi_q    <= req_i.init;
      lo_q    <= req_i.mplier;
    end else if (run_q) begin
      hi_q    <= hi_d;
      lo_q    <= lo_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hi   = hi_q;
  assign rsp_o.lo   = lo_q;

  `FMO_ASSERT(a_no_restart, req_i.start |-> !run_q, "multiply started while one is running")
  `FMO_ASSERT(a_done_pulse, done_q |=> !done_q, "multiply done held longer than one cycle")

endmodule

/* src/fm_two_operator_oscillator.sv */
// Two-operator FM oscillator: each transfer on the input stream is one sample tick and yields
// one signed Q1.15 sample on the output stream. On a sounding tick the modulator phase reads
// the 1024-entry sine ROM with linear interpolation, the value is scaled by mod_depth and
// added to the carrier phase, the ROM is read again at that inner phase, scaled by amplitude,
// rounded half up and saturated; then both phases advance modulo the table length. A silent
// tick gives sample 0 and leaves the phases alone, going straight
// from its input transfer to the output step. The four multiplications share one multiplier
// that takes a 4-bit digit per cycle, and they take 4, 6, 4 and 4 digits. The next input is
// taken as soon as the result is registered, even while that result still waits on the
// output; a new result waits in its last step only while the output register is still full.
// Register writes are taken at any time but belong between ticks. The ROM is a constant table
// with two registered read ports and needs no fill after reset.
`include "fm_two_operator_oscillator_assert.svh"

module fm_two_operator_oscillator
  import fmo_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream, tdata: [0] sounding, [7:1] zero
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,
  // output stream, tdata: [15:0] sample (signed)
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [15:0]          m_axis_tdata_o,
  // register write port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  // control registers
  logic [StepW-1:0]   carrier_step_q;
  logic [StepW-1:0]   mod_step_q;
  logic [DepthW-1:0]  depth_q;
  logic [AmpW-1:0]    amp_q;

  // oscillator state
  logic [PhaseW-1:0]  carrier_q;
  logic [PhaseW-1:0]  mod_q;
  logic [PhaseW-1:0]  inner_q;
  logic [PhaseW-1:0]  inner_d;
  logic               sounding_q;

  fmo_state_e         state_q;
  fmo_state_e         state_d;

  // result and output register
  logic signed [SampleW-1:0] result_q;
  logic signed [SampleW-1:0] result_d;
  logic signed [SampleW-1:0] out_sample_q;
  logic                      out_valid_q;
  logic                      out_load;
  logic                      in_xfer;

  // rom and multiplier
  logic [PhaseW-1:0]         rom_ph;
  logic signed [15:0]        rom_a;
  logic signed [15:0]        rom_b;
  logic signed [16:0]        rom_diff;
  fmo_mul_req_t              mul_req;
  fmo_mul_rsp_t              mul_rsp;
  logic signed [McandW-1:0]  lerp_val;
  logic signed [AccW-OutShift-1:0] y_wide;
  logic                      y_ovf;

  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_sample_q;

  // the modulator address is set up while waiting, the inner phase afterwards
  assign rom_ph = (state_q == StIdle) ? mod_q : inner_q;

  fmo_rom u_rom (
    .clk_i (clk_i),
    .idx_i (rom_ph[PhaseW-1:FracW]),
    .a_o   (rom_a),
    .b_o   (rom_b)
  );

  fmo_dmul u_dmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign rom_diff = 17'(rom_b) - 17'(rom_a);

  // interpolated value after four digits: hi carries weight 2^16, lo holds the fraction bits
  assign lerp_val = {mul_rsp.hi[McandW-FracW-1:0], mul_rsp.lo[MulBW-1 -: FracW]};

  // output sample before saturation
  assign y_wide = mul_rsp.hi[AccW-1:OutShift];
  assign y_ovf  = (y_wide[AccW-OutShift-1:SampleW-1] != '0)
               && (y_wide[AccW-OutShift-1:SampleW-1] != '1);

  always_comb begin
    state_d  = state_q;
    inner_d  = inner_q;
    result_d = result_q;
    out_load = 1'b0;
    mul_req  = '0;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          result_d = '0;
          state_d  = s_axis_tdata_i[0] ? StRdMod : StDone;
        end
      end
      StRdMod: begin
        // modulator lerp: a * 2^16 + (b - a) * frac
        mul_req.start  = 1'b1;
        mul_req.ndig   = FracDigits;
        mul_req.init   = {{(AccW-32){rom_a[15]}}, rom_a, 16'b0};
        mul_req.mcand  = McandW'(rom_diff);
        mul_req.mplier = MulBW'(mod_q[FracW-1:0]);
        state_d        = StLerpMod;
      end
      StLerpMod: begin
        if (mul_rsp.done) begin
          mul_req.start  = 1'b1;
          mul_req.ndig   = DepthDigits;
          mul_req.init   = '0;
          mul_req.mcand  = lerp_val;
          mul_req.mplier = depth_q;
          state_d        = StDepth;
        end
      end
      StDepth: begin
        if (mul_rsp.done) begin
          // wraps modulo the table length through the phase width
          inner_d = carrier_q + mul_rsp.hi[PhaseW+OffShift-1:OffShift];
          state_d = StRdCar;
        end
      end
      StRdCar: begin
        state_d = StLdCar;
      end
      StLdCar: begin
        mul_req.start  = 1'b1;
        mul_req.ndig   = FracDigits;
        mul_req.init   = {{(AccW-32){rom_a[15]}}, rom_a, 16'b0};
        mul_req.mcand  = McandW'(rom_diff);
        mul_req.mplier = MulBW'(inner_q[FracW-1:0]);
        state_d        = StLerpCar;
      end
      StLerpCar: begin
        if (mul_rsp.done) begin
          // amplitude gain with the rounding half added up front
          mul_req.start  = 1'b1;
          mul_req.ndig   = FracDigits;
          mul_req.init   = AccW'(64'd1 << 30);
          mul_req.mcand  = lerp_val;
          mul_req.mplier = MulBW'(amp_q);
          state_d        = StAmp;
        end
      end
      StAmp: begin
        if (mul_rsp.done) begin
          if (y_ovf) begin
            result_d = y_wide[AccW-OutShift-1] ? {1'b1, {(SampleW-1){1'b0}}}
                                               : {1'b0, {(SampleW-1){1'b1}}};
          end else begin
            result_d = y_wide[SampleW-1:0];
          end
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_step_q <= '0;
      mod_step_q     <= '0;
      depth_q        <= '0;
      amp_q          <= '0;
    end else if (cfg_we_i) begin
      unique case (fmo_cfg_e'(cfg_idx_i))
        CfgCarrierStep: carrier_step_q <= cfg_data_i;
        CfgModStep:     mod_step_q     <= cfg_data_i;
        CfgModDepth:    depth_q        <= cfg_data_i[DepthW-1:0];
        CfgAmplitude:   amp_q          <= cfg_data_i[AmpW-1:0];
        default:        ;
      endcase
    end
  end

  // phases advance when a sounding tick hands its sample over
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_q   <= '0;
      mod_q       <= '0;
      sounding_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        sounding_q <= s_axis_tdata_i[0];
      end
      if (out_load && sounding_q) begin
        carrier_q <= carrier_q + PhaseW'(carrier_step_q);
        mod_q     <= mod_q + PhaseW'(mod_step_q);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    inner_q  <= inner_d;
    result_q <= result_d;
    if (out_load) begin
      out_sample_q <= result_q;
    end
  end

  `FMO_ASSERT(a_silent_hold, (out_load && !sounding_q) |=> $stable(carrier_q) && $stable(mod_q), "phase moved on a silent tick")
  `FMO_ASSERT(a_silent_zero, (out_load && !sounding_q) |=> (out_sample_q == '0), "silent tick gave a nonzero sample")
  `FMO_ASSERT(a_done_waiting, mul_rsp.done |-> (state_q == StLerpMod || state_q == StDepth || state_q == StLerpCar || state_q == StAmp), "multiply finished outside a wait step")

endmodule
